// ===== hw/rtl/piecewise_polynomial_eval_assert.svh =====
// assertion macros used by the piecewise polynomial evaluator controller
`ifndef PIECEWISE_POLYNOMIAL_EVAL_ASSERT_SVH
`define PIECEWISE_POLYNOMIAL_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppe assertion failed");
`define PPE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppe assertion failed");
`else
`define PPE_ASSERT_IMP(lbl, ante, cons)
`define PPE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ppe_pkg.sv =====
// shared types, constants and tables of the piecewise polynomial evaluator
`default_nettype none
package ppe_pkg;
   localparam int NUM_PIECES = 8;
   localparam int MAX_COEFS  = 8;
   localparam int SLOT_W     = $clog2(NUM_PIECES);
   localparam int COEF_W     = $clog2(MAX_COEFS);
   localparam int CNT_W      = $clog2(NUM_PIECES + 1);
   localparam int CCNT_W     = $clog2(MAX_COEFS + 1);
   localparam int TBL_DEPTH  = NUM_PIECES * MAX_COEFS;

   // function codes carried in tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   // table word indexes
   localparam logic [4:0] WORD_BEGIN = 5'd0;
   localparam logic [4:0] WORD_END   = 5'd1;
   localparam logic [4:0] WORD_COUNT = 5'd2;
   localparam logic [4:0] WORD_COEF  = 5'd3;
   localparam logic [4:0] WORD_SCALE = 5'(3 + MAX_COEFS);
   localparam logic [4:0] WORD_LAST  = 5'(2 + 2 * MAX_COEFS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_NDIV, ST_PINIT, ST_TRD, ST_TMUL, ST_TACC,
      ST_SMUL, ST_SACC, ST_ADIV, ST_DONE
   } state_type;

   typedef struct packed {
      logic ld_write;
      logic ev_start;
      logic slot_inc;
      logic norm_start;
      logic avg_start;
      logic div_step;
      logic pv_init;
      logic term_mul;
      logic term_acc;
      logic scale_mul;
      logic scale_acc;
      logic add_zero;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic in_range;
      logic hit;
      logic div_last;
      logic order_ge_cnt;
      logic idx_zero;
      logic num_zero;
      logic rsp_free;
   } status_type;

   // falling factorial weights indexed by {k, order}
   typedef logic [12:0] fall_tbl_type [0:63];

   function automatic fall_tbl_type build_fall();
      fall_tbl_type tbl;
      int w;
      for (int k = 0; k < 8; k++) begin
         for (int o = 0; o < 8; o++) begin
            w = 1;
            for (int j = 0; j < o; j++) begin
               w = w * (k - j);
            end
            tbl[k * 8 + o] = 13'(w);
         end
      end
      return tbl;
   endfunction

   localparam fall_tbl_type FALL_TBL = build_fall();
endpackage
`default_nettype wire

// ===== hw/rtl/ppe_ram.sv =====
// generic single write port memory with registered read
`default_nettype none
module ppe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/ppe_datapath.sv =====
// piece table, shared divider, term arithmetic and result register
`default_nettype none
module ppe_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [2:0]          req_slot,
   input  wire logic [4:0]          req_word_index,
   input  wire logic signed [31:0]  req_load_value,
   input  wire logic signed [31:0]  req_position,
   input  wire logic [2:0]          req_deriv_order,
   input  wire logic                csr_valid,
   input  wire logic [3:0]          csr_data,
   input  wire ppe_pkg::cmd_type    cmd,
   output ppe_pkg::status_type      status,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic signed [31:0]       rsp_value,
   output logic [3:0]               rsp_pieces_matched,
   output logic                     rsp_saturated
);
   localparam int SW = ppe_pkg::SLOT_W;
   localparam int CW = ppe_pkg::COEF_W;
   localparam int AW = $clog2(ppe_pkg::TBL_DEPTH);

   logic [3:0]                  piu_ff;
   logic signed [31:0]          begin_ff [0:ppe_pkg::NUM_PIECES-1];
   logic signed [31:0]          end_ff   [0:ppe_pkg::NUM_PIECES-1];
   logic [ppe_pkg::CCNT_W-1:0]  count_ff [0:ppe_pkg::NUM_PIECES-1];
   logic [ppe_pkg::CCNT_W-1:0]  count_in;

   logic signed [31:0] t_ff;
   logic [2:0]         order_ff;
   logic [3:0]         slot_ff;
   logic               hit_ff;
   logic [3:0]         num_ff;
   logic signed [34:0] sum_ff, sum_in;
   logic               sat_ff;

   logic [32:0] rem_ff, dsr_ff;
   logic [34:0] quo_ff;
   logic [5:0]  div_cnt_ff;
   logic [33:0] rem_sh;
   logic        div_ge;

   logic [15:0]        u_ff;
   logic [16:0]        power_ff;
   logic [CW-1:0]      idx_ff;
   logic [2:0]         k_ff;
   logic signed [31:0] prod_ff;
   logic signed [49:0] acc_ff;
   logic signed [63:0] spv_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [3:0]         rsp_num_ff;
   logic               rsp_sat_ff;

   logic [3:0]         n_lim;
   logic signed [31:0] cur_begin, cur_end;
   logic signed [32:0] diff_t, span;
   logic [31:0]        coef_rd, scale_rd;
   logic signed [49:0] coef_prod;
   logic [32:0]        pow_prod;
   logic signed [45:0] term;
   logic signed [31:0] acc_cl, pv_cl;
   logic               acc_sat, pv_sat;
   logic signed [47:0] pv_sh;
   logic [34:0]        sum_abs;
   logic [12:0]        weight;
   logic [4:0]         coef_off, scale_off;
   logic               coef_we, scale_we;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         piu_ff <= '0;
      end else if (csr_valid) begin
         piu_ff <= csr_data;
      end
   end

   // piece bounds and counts, written by load transactions
   always_comb begin
      if (req_load_value < 0) begin
         count_in = '0;
      end else if (req_load_value > ppe_pkg::MAX_COEFS) begin
         count_in = ppe_pkg::CCNT_W'(ppe_pkg::MAX_COEFS);
      end else begin
         count_in = req_load_value[ppe_pkg::CCNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_write) begin
         case (req_word_index)
            ppe_pkg::WORD_BEGIN: begin_ff[req_slot[SW-1:0]] <= req_load_value;
            ppe_pkg::WORD_END:   end_ff[req_slot[SW-1:0]]   <= req_load_value;
            ppe_pkg::WORD_COUNT: count_ff[req_slot[SW-1:0]] <= count_in;
            default: ;
         endcase
      end
   end

   // coefficient and scale memories
   assign coef_off  = req_word_index - ppe_pkg::WORD_COEF;
   assign scale_off = req_word_index - ppe_pkg::WORD_SCALE;
   assign coef_we   = cmd.ld_write && req_word_index >= ppe_pkg::WORD_COEF
                      && req_word_index < ppe_pkg::WORD_SCALE;
   assign scale_we  = cmd.ld_write && req_word_index >= ppe_pkg::WORD_SCALE
                      && req_word_index <= ppe_pkg::WORD_LAST;

   ppe_ram #(.WIDTH(32), .DEPTH(ppe_pkg::TBL_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr ({req_slot[SW-1:0], coef_off[CW-1:0]}),
      .wr_data (req_load_value),
      .rd_addr ({slot_ff[SW-1:0], idx_ff}),
      .rd_data (coef_rd)
   );

   ppe_ram #(.WIDTH(32), .DEPTH(ppe_pkg::TBL_DEPTH)) u_scale_ram (
      .clock   (clock),
      .wr_en   (scale_we),
      .wr_addr ({req_slot[SW-1:0], scale_off[CW-1:0]}),
      .wr_data (req_load_value),
      .rd_addr ({slot_ff[SW-1:0], order_ff[CW-1:0]}),
      .rd_data (scale_rd)
   );

   // scan compare for the current slot
   assign n_lim     = (piu_ff > 4'(ppe_pkg::NUM_PIECES)) ? 4'(ppe_pkg::NUM_PIECES) : piu_ff;
   assign cur_begin = begin_ff[slot_ff[SW-1:0]];
   assign cur_end   = end_ff[slot_ff[SW-1:0]];
   assign diff_t    = {t_ff[31], t_ff} - {cur_begin[31], cur_begin};
   assign span      = {cur_end[31], cur_end} - {cur_begin[31], cur_begin};

   // restoring divider step
   assign rem_sh = {rem_ff, quo_ff[34]};
   assign div_ge = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (cmd.norm_start) begin
         rem_ff     <= diff_t[32:0];
         quo_ff     <= '0;
         dsr_ff     <= span[32:0];
         div_cnt_ff <= 6'd16;
      end else if (cmd.avg_start) begin
         rem_ff     <= '0;
         quo_ff     <= sum_abs;
         dsr_ff     <= {29'd0, num_ff};
         div_cnt_ff <= 6'd35;
      end else if (cmd.div_step) begin
         rem_ff     <= div_ge ? 33'(rem_sh - {1'b0, dsr_ff}) : rem_sh[32:0];
         quo_ff     <= {quo_ff[33:0], div_ge};
         div_cnt_ff <= div_cnt_ff - 6'd1;
      end
   end

   // term arithmetic
   assign coef_prod = $signed(coef_rd) * $signed({1'b0, power_ff});
   assign pow_prod  = power_ff * u_ff;
   assign weight    = ppe_pkg::FALL_TBL[{k_ff, order_ff}];
   assign term      = $signed({1'b0, weight}) * prod_ff;

   always_comb begin
      acc_sat = 1'b0;
      acc_cl  = acc_ff[31:0];
      if (!acc_ff[49] && (|acc_ff[48:31])) begin
         acc_sat = 1'b1;
         acc_cl  = 32'sh7fffffff;
      end else if (acc_ff[49] && !(&acc_ff[48:31])) begin
         acc_sat = 1'b1;
         acc_cl  = 32'sh80000000;
      end
   end

   assign pv_sh = spv_ff[63:16];

   always_comb begin
      pv_sat = 1'b0;
      pv_cl  = pv_sh[31:0];
      if (!pv_sh[47] && (|pv_sh[46:31])) begin
         pv_sat = 1'b1;
         pv_cl  = 32'sh7fffffff;
      end else if (pv_sh[47] && !(&pv_sh[46:31])) begin
         pv_sat = 1'b1;
         pv_cl  = 32'sh80000000;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pv_init) begin
         u_ff     <= quo_ff[15:0];
         power_ff <= 17'h10000;
         acc_ff   <= '0;
         idx_ff   <= CW'(count_ff[slot_ff[SW-1:0]] - 4'd1 - {1'b0, order_ff});
         k_ff     <= order_ff;
      end
      if (cmd.term_mul) begin
         prod_ff  <= coef_prod[47:16];
         power_ff <= pow_prod[32:16];
      end
      if (cmd.term_acc) begin
         acc_ff <= acc_ff + {{4{term[45]}}, term};
         idx_ff <= idx_ff - CW'(1);
         k_ff   <= k_ff + 3'd1;
      end
      if (cmd.scale_mul) begin
         spv_ff <= acc_cl * $signed(scale_rd);
      end
   end

   // evaluation bookkeeping
   assign sum_in  = sum_ff + {{3{pv_cl[31]}}, pv_cl};
   assign sum_abs = sum_ff[34] ? 35'(-sum_ff) : sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.ev_start) begin
         t_ff     <= req_position;
         order_ff <= req_deriv_order;
         slot_ff  <= '0;
         hit_ff   <= 1'b0;
         num_ff   <= '0;
         sum_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         if (cmd.slot_inc || cmd.add_zero || cmd.scale_acc) begin
            slot_ff <= slot_ff + 4'd1;
         end
         if (cmd.add_zero || cmd.scale_acc) begin
            num_ff <= num_ff + 4'd1;
            hit_ff <= 1'b1;
         end
         if (cmd.scale_mul && acc_sat) begin
            sat_ff <= 1'b1;
         end
         if (cmd.scale_acc) begin
            sum_ff <= sum_in;
            if (pv_sat) begin
               sat_ff <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (num_ff == 4'd0) begin
            rsp_value_ff <= '0;
         end else if (sum_ff[34]) begin
            rsp_value_ff <= -$signed(quo_ff[31:0]);
         end else begin
            rsp_value_ff <= $signed(quo_ff[31:0]);
         end
         rsp_num_ff <= num_ff;
         rsp_sat_ff <= sat_ff;
      end
   end

   // status to the controller
   always_comb begin
      status.scan_end     = slot_ff >= n_lim;
      status.in_range     = (t_ff >= cur_begin) && (t_ff < cur_end);
      status.hit          = hit_ff;
      status.div_last     = div_cnt_ff == 6'd1;
      status.order_ge_cnt = {1'b0, order_ff} >= count_ff[slot_ff[SW-1:0]];
      status.idx_zero     = idx_ff == '0;
      status.num_zero     = num_ff == 4'd0;
      status.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_pieces_matched = rsp_num_ff;
   assign rsp_saturated      = rsp_sat_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/ppe_controller.sv =====
// load and evaluation sequencer: load write, scan, normalize, term loop, scale, average
`default_nettype none
`include "piecewise_polynomial_eval_assert.svh"
module ppe_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_func,
   output logic                    req_tready,
   input  wire ppe_pkg::status_type status,
   output ppe_pkg::cmd_type        cmd
);
   ppe_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ppe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == ppe_pkg::FUNC_LOAD) begin
                  cmd.ld_write = 1'b1;
               end else begin
                  cmd.ev_start = 1'b1;
                  state_in     = ppe_pkg::ST_SCAN;
               end
            end
         end
         ppe_pkg::ST_SCAN: begin
            if (status.scan_end || (!status.in_range && status.hit)) begin
               if (status.num_zero) begin
                  state_in = ppe_pkg::ST_DONE;
               end else begin
                  cmd.avg_start = 1'b1;
                  state_in      = ppe_pkg::ST_ADIV;
               end
            end else if (status.in_range) begin
               cmd.norm_start = 1'b1;
               state_in       = ppe_pkg::ST_NDIV;
            end else begin
               cmd.slot_inc = 1'b1;
            end
         end
         ppe_pkg::ST_NDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ppe_pkg::ST_PINIT;
            end
         end
         ppe_pkg::ST_PINIT: begin
            if (status.order_ge_cnt) begin
               cmd.add_zero = 1'b1;
               state_in     = ppe_pkg::ST_SCAN;
            end else begin
               cmd.pv_init = 1'b1;
               state_in    = ppe_pkg::ST_TRD;
            end
         end
         ppe_pkg::ST_TRD: begin
            state_in = ppe_pkg::ST_TMUL;
         end
         ppe_pkg::ST_TMUL: begin
            cmd.term_mul = 1'b1;
            state_in     = ppe_pkg::ST_TACC;
         end
         ppe_pkg::ST_TACC: begin
            cmd.term_acc = 1'b1;
            state_in     = status.idx_zero ? ppe_pkg::ST_SMUL : ppe_pkg::ST_TRD;
         end
         ppe_pkg::ST_SMUL: begin
            cmd.scale_mul = 1'b1;
            state_in      = ppe_pkg::ST_SACC;
         end
         ppe_pkg::ST_SACC: begin
            cmd.scale_acc = 1'b1;
            state_in      = ppe_pkg::ST_SCAN;
         end
         ppe_pkg::ST_ADIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ppe_pkg::ST_DONE;
            end
         end
         ppe_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ppe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppe_pkg::ST_IDLE;
         end
      endcase
   end

   // checks
   `PPE_ASSERT_IMP(a_div_step_state, cmd.div_step,
      state_ff == ppe_pkg::ST_NDIV || state_ff == ppe_pkg::ST_ADIV)
   `PPE_ASSERT_IMP(a_rsp_load_free, cmd.rsp_load, status.rsp_free)
   `PPE_ASSERT_NXT(a_ev_start_scan, cmd.ev_start, state_ff == ppe_pkg::ST_SCAN)
   `PPE_ASSERT_NXT(a_term_loop, cmd.term_acc && !status.idx_zero,
      state_ff == ppe_pkg::ST_TRD)
endmodule
`default_nettype wire

// ===== hw/rtl/piecewise_polynomial_eval.sv =====
// Piecewise polynomial evaluator, top level. Load transactions (tuser 0) write one
// word of the piece table. Evaluate transactions (tuser 1) scan slots from zero;
// every matching piece takes a slot check, a normalizing divide, a setup step, a
// read, multiply and accumulate step for each coefficient term and a scale multiply
// and accumulate (a matching piece whose count does not exceed the order skips the
// term loop and scaling and adds zero), a missing slot takes one slot check, and the
// average takes a divide when anything matched. One item is worked on at a time; the
// next is taken while the result waits in its register.
`default_nettype none
module piecewise_polynomial_eval (
   input  wire logic        clock,
   input  wire logic        reset,
   // tdata: slot[2:0], word_index[7:3], load_value[39:8], position[71:40],
   // deriv_order[74:72], zero fill [79:75]
   input  wire logic [79:0] req_tdata,
   input  wire logic        req_tuser,   // func
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [3:0]  csr_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   // tdata: value[31:0], pieces_matched[35:32], zero fill [39:36]
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tuser,   // saturated
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);
   ppe_pkg::cmd_type    cmd;
   ppe_pkg::status_type status;
   logic signed [31:0]  rsp_value;
   logic [3:0]          rsp_num;

   ppe_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppe_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_slot           (req_tdata[2:0]),
      .req_word_index     (req_tdata[7:3]),
      .req_load_value     (req_tdata[39:8]),
      .req_position       (req_tdata[71:40]),
      .req_deriv_order    (req_tdata[74:72]),
      .csr_valid          (csr_valid),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_value          (rsp_value),
      .rsp_pieces_matched (rsp_num),
      .rsp_saturated      (rsp_tuser)
   );

   // configuration writes are always taken
   assign csr_ready = 1'b1;
   assign rsp_tdata = {4'd0, rsp_num, rsp_value};
endmodule
`default_nettype wire
